### src/three_way_bucket_store_macros.svh
// Assertion macros used by the bucket store RTL.
// Every macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef THREE_WAY_BUCKET_STORE_MACROS_SVH
`define THREE_WAY_BUCKET_STORE_MACROS_SVH

`ifndef SYNTH
`define TBS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define TBS_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define TBS_ASSERT(lbl, prop, msg)
`define TBS_NEVER(lbl, expr, msg)
`endif

`endif

### src/tbs_pkg.sv
`default_nettype none

package tbs_pkg;

   localparam int SLOT_COUNT    = 3;
   localparam int PAYLOAD_BITS  = 64;
   localparam int KEY_BITS      = 64;
   localparam int FIELD_BITS    = 64;
   localparam int SLOT_IDX_BITS = 2;
   localparam int STATUS_BITS   = 3;
   localparam int COUNT_BITS    = 2;

   typedef logic [SLOT_IDX_BITS-1:0] slot_idx_type;
   typedef logic [STATUS_BITS-1:0]   status_type;

   localparam logic OP_STORE  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   localparam status_type ST_UPDATE  = 3'd0;
   localparam status_type ST_NEW     = 3'd1;
   localparam status_type ST_COLLIDE = 3'd2;
   localparam status_type ST_HIT     = 3'd3;
   localparam status_type ST_MISS    = 3'd4;

   typedef struct packed {
      logic                  operation;
      logic [KEY_BITS-1:0]   key_hash;
      logic [FIELD_BITS-1:0] entry_payload;
   } request_type;

   typedef struct packed {
      status_type            status;
      logic [FIELD_BITS-1:0] found_payload;
      logic [COUNT_BITS-1:0] live_count;
   } result_type;

   function automatic slot_idx_type slot_wrap(input slot_idx_type idx);
      return (idx >= slot_idx_type'(SLOT_COUNT)) ? '0 : idx;
   endfunction

   function automatic slot_idx_type slot_next(input slot_idx_type idx);
      return (idx == slot_idx_type'(SLOT_COUNT - 1)) ? '0 : idx + 1'b1;
   endfunction

   function automatic slot_idx_type slot_prev(input slot_idx_type idx);
      return (idx == '0) ? slot_idx_type'(SLOT_COUNT - 1) : idx - 1'b1;
   endfunction

endpackage

`default_nettype wire

### src/tbs_bucket.sv
`default_nettype none

`include "three_way_bucket_store_macros.svh"

module tbs_bucket
   import tbs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        commit,
   input  wire request_type req,
   output result_type       result
);

   logic [KEY_BITS-1:0]     slot_key_ff  [SLOT_COUNT];
   logic [PAYLOAD_BITS-1:0] slot_data_ff [SLOT_COUNT];
   logic [SLOT_COUNT-1:0]   slot_live_ff;
   slot_idx_type            recent_ff;

   slot_idx_type            cur;
   slot_idx_type            prior;
   slot_idx_type            after;
   logic [SLOT_COUNT-1:0]   key_eq;
   logic [SLOT_COUNT-1:0]   hit_sel;
   logic [SLOT_COUNT-1:0]   wr_sel;
   logic [SLOT_COUNT-1:0]   live_next;
   logic                    wr_en;
   slot_idx_type            wr_idx;
   status_type              status;
   logic [PAYLOAD_BITS-1:0] found;
   logic [COUNT_BITS-1:0]   count;

   always_comb begin
      cur    = slot_wrap(recent_ff);
      prior  = slot_prev(cur);
      after  = slot_next(cur);
      for (int i = 0; i < SLOT_COUNT; i++) begin
         key_eq[i] = (slot_key_ff[i] == req.key_hash);
      end
      wr_en   = 1'b0;
      wr_idx  = after;
      hit_sel = '0;
      status  = ST_MISS;
      if (req.operation == OP_STORE) begin
         wr_en = 1'b1;
         priority if (key_eq[cur]) begin
            wr_idx = cur;
            status = ST_UPDATE;
         end else if (key_eq[prior]) begin
            wr_idx = prior;
            status = ST_UPDATE;
         end else if (key_eq[after]) begin
            wr_idx = after;
            status = ST_UPDATE;
         end else if (!slot_live_ff[after]) begin
            wr_idx = after;
            status = ST_NEW;
         end else if (!slot_live_ff[prior]) begin
            wr_idx = prior;
            status = ST_NEW;
         end else if (!slot_live_ff[cur]) begin
            wr_idx = cur;
            status = ST_NEW;
         end else begin
            wr_idx = after;
            status = ST_COLLIDE;
         end
      end else begin
         priority if (slot_live_ff[cur] && key_eq[cur]) begin
            hit_sel[cur] = 1'b1;
            status       = ST_HIT;
         end else if (slot_live_ff[prior] && key_eq[prior]) begin
            hit_sel[prior] = 1'b1;
            status         = ST_HIT;
         end else if (slot_live_ff[after] && key_eq[after]) begin
            hit_sel[after] = 1'b1;
            status         = ST_HIT;
         end else begin
            status = ST_MISS;
         end
      end
      found = '0;
      count = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         wr_sel[i]    = wr_en && (wr_idx == slot_idx_type'(i));
         live_next[i] = slot_live_ff[i] | wr_sel[i];
         count        = count + COUNT_BITS'(live_next[i]);
         if (hit_sel[i]) begin
            found = found | slot_data_ff[i];
         end
      end
      result.status        = status;
      result.found_payload = FIELD_BITS'(found);
      result.live_count    = count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_key_ff[i]  <= '0;
            slot_data_ff[i] <= '0;
         end
         slot_live_ff <= '0;
         recent_ff    <= '0;
      end else if (commit && wr_en) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            if (wr_sel[i]) begin
               slot_key_ff[i]  <= req.key_hash;
               slot_data_ff[i] <= req.entry_payload[PAYLOAD_BITS-1:0];
            end
         end
         slot_live_ff <= live_next;
         recent_ff    <= wr_idx;
      end
   end

   `TBS_NEVER(a_ptr_range, recent_ff >= slot_idx_type'(SLOT_COUNT), "pointer out of range")
   `TBS_ASSERT(a_ptr_follows_write, (commit && req.operation == OP_STORE) |=> (recent_ff == $past(wr_idx)), "pointer did not move to written slot")
   `TBS_ASSERT(a_lookup_keeps_ptr, (commit && req.operation == OP_LOOKUP) |=> $stable(recent_ff), "lookup moved the pointer")
   `TBS_ASSERT(a_live_sticky, 1'b1 |=> ((slot_live_ff & $past(slot_live_ff)) == $past(slot_live_ff)), "live slot was cleared")

endmodule

`default_nettype wire

### src/tbs_rsp_reg.sv
`default_nettype none

module tbs_rsp_reg
   import tbs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire result_type            result,
   output logic                       can_load,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [STATUS_BITS-1:0]     rsp_status,
   output logic [FIELD_BITS-1:0]      rsp_found_payload,
   output logic [COUNT_BITS-1:0]      rsp_live_count
);

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   always_comb begin
      can_load = !valid_ff || rsp_ready;
      valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_status        = data_ff.status;
   assign rsp_found_payload = data_ff.found_payload;
   assign rsp_live_count    = data_ff.live_count;

endmodule

`default_nettype wire

### src/three_way_bucket_store.sv
// Three-slot hash bucket with a last-written pointer.
// The req channel carries one word per operation: operation (store or lookup),
// key_hash and entry_payload. The rsp channel returns exactly one word per
// request, in order: status (update, new, collide, hit or miss), found_payload
// and the live-slot count after the operation.
// A request is captured in an input register; once the output register can take a
// word, the bucket is read and updated and the result is written into the output
// register, which drives rsp_valid.
// Throughput is one word per cycle while rsp_ready is high: the bucket
// read-modify-write on the three slot registers and the pointer is
// combinational, so each operation sees the state left by the previous one.
// Reset clears all keys and payloads to zero, marks every slot empty and sets
// the pointer to slot zero; rsp_valid drops and the input register empties.
// When the receiver holds rsp_ready low, the result word waits in the output
// register, one more request waits in the input register, and then req_ready
// falls until the output register drains.
`default_nettype none

module three_way_bucket_store
   import tbs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_operation,
   input  wire logic [KEY_BITS-1:0]   req_key_hash,
   input  wire logic [FIELD_BITS-1:0] req_entry_payload,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [STATUS_BITS-1:0]     rsp_status,
   output logic [FIELD_BITS-1:0]      rsp_found_payload,
   output logic [COUNT_BITS-1:0]      rsp_live_count
);

   logic        s1_valid_ff;
   logic        s1_valid_in;
   request_type s1_req_ff;
   logic        req_accept;
   logic        advance;
   logic        rsp_can_load;
   result_type  bucket_result;

   always_comb begin
      advance     = s1_valid_ff && rsp_can_load;
      req_ready   = !s1_valid_ff || advance;
      req_accept  = req_valid && req_ready;
      s1_valid_in = req_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff.operation     <= req_operation;
         s1_req_ff.key_hash      <= req_key_hash;
         s1_req_ff.entry_payload <= req_entry_payload;
      end
   end

   tbs_bucket u_bucket (
      .clock  (clock),
      .reset  (reset),
      .commit (advance),
      .req    (s1_req_ff),
      .result (bucket_result)
   );

   tbs_rsp_reg u_rsp_reg (
      .clock             (clock),
      .reset             (reset),
      .load              (advance),
      .result            (bucket_result),
      .can_load          (rsp_can_load),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_found_payload (rsp_found_payload),
      .rsp_live_count    (rsp_live_count)
   );

endmodule

`default_nettype wire

### tb/tb_three_way_bucket_store.sv
`timescale 1ns / 100ps

module tb_three_way_bucket_store;
   import tbs_pkg::*;

   typedef struct {
      logic                  operation;
      logic [KEY_BITS-1:0]   key_hash;
      logic [FIELD_BITS-1:0] entry_payload;
      bit                    fixed_answer;
      result_type            answer;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_operation = OP_STORE;
   logic [KEY_BITS-1:0]    req_key_hash = '0;
   logic [FIELD_BITS-1:0]  req_entry_payload = '0;
   logic                   rsp_ready = 1'b0;
   logic                   req_ready;
   logic                   rsp_valid;
   logic [STATUS_BITS-1:0] rsp_status;
   logic [FIELD_BITS-1:0]  rsp_found_payload;
   logic [COUNT_BITS-1:0]  rsp_live_count;

   logic [KEY_BITS-1:0]     bucket_key [SLOT_COUNT];
   logic [PAYLOAD_BITS-1:0] bucket_data [SLOT_COUNT];
   bit                      bucket_live [SLOT_COUNT];
   int                      recent_index;

   result_type   pending_results [$];
   stim_row_type directed_rows [$];
   int           error_count = 0;
   bit           steady_flow = 1'b0;

   three_way_bucket_store dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_key_hash      (req_key_hash),
      .req_entry_payload (req_entry_payload),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_found_payload (rsp_found_payload),
      .rsp_live_count    (rsp_live_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic result_type bucket_apply(input logic op,
                                               input logic [KEY_BITS-1:0] key,
                                               input logic [FIELD_BITS-1:0] data);
      result_type res;
      int         cur;
      int         prior;
      int         oldest;
      int         target;
      int         idx;
      res.status        = ST_MISS;
      res.found_payload = '0;
      res.live_count    = '0;
      cur    = recent_index % SLOT_COUNT;
      prior  = (cur + 2) % SLOT_COUNT;
      oldest = (cur + 1) % SLOT_COUNT;
      if (op == OP_STORE) begin
         res.status = ST_UPDATE;
         if (bucket_key[cur] == key) begin
            target = cur;
         end else if (bucket_key[prior] == key) begin
            target = prior;
         end else if (bucket_key[oldest] == key) begin
            target = oldest;
         end else begin
            res.status = ST_COLLIDE;
            target = oldest;
            for (int i = 0; i < SLOT_COUNT; i++) begin
               idx = (cur + 1 + i) % SLOT_COUNT;
               if (res.status == ST_COLLIDE && !bucket_live[idx]) begin
                  target = idx;
                  res.status = ST_NEW;
               end
            end
         end
         bucket_key[target]  = key;
         bucket_data[target] = data[PAYLOAD_BITS-1:0];
         bucket_live[target] = 1'b1;
         recent_index = target;
      end else begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            idx = (cur + SLOT_COUNT - i) % SLOT_COUNT;
            if (res.status == ST_MISS && bucket_live[idx] && bucket_key[idx] == key) begin
               res.status = ST_HIT;
               res.found_payload = FIELD_BITS'(bucket_data[idx]);
            end
         end
      end
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (bucket_live[i]) begin
            res.live_count = res.live_count + 1'b1;
         end
      end
      return res;
   endfunction

   task automatic add_row(input logic op, input logic [KEY_BITS-1:0] key,
                          input logic [FIELD_BITS-1:0] data, input bit fixed,
                          input status_type status, input logic [FIELD_BITS-1:0] found,
                          input logic [COUNT_BITS-1:0] live);
      stim_row_type row;
      row.operation             = op;
      row.key_hash              = key;
      row.entry_payload         = data;
      row.fixed_answer          = fixed;
      row.answer.status         = status;
      row.answer.found_payload  = found;
      row.answer.live_count     = live;
      directed_rows.push_back(row);
   endtask

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic send_word(input stim_row_type row);
      result_type predicted;
      while (!steady_flow && $urandom_range(99) < 6) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid         = 1'b1;
      req_operation     = row.operation;
      req_key_hash      = row.key_hash;
      req_entry_payload = row.entry_payload;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      predicted = bucket_apply(row.operation, row.key_hash, row.entry_payload);
      pending_results.push_back(row.fixed_answer ? row.answer : predicted);
      @(negedge clock);
   endtask

   task automatic drain_results;
      req_valid = 1'b0;
      while (pending_results.size() != 0) begin
         @(negedge clock);
      end
   endtask

   always @(negedge clock) begin
      rsp_ready = steady_flow || ($urandom_range(99) >= 6);
   end

   always @(posedge clock) begin : result_check
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result word with none expected, actual status %0d payload %h count %0d",
                     $time, rsp_status, rsp_found_payload, rsp_live_count);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
               error_count++;
            end
            if (rsp_found_payload !== want.found_payload) begin
               $display("%0t: found_payload expected %h actual %h", $time,
                        want.found_payload, rsp_found_payload);
               error_count++;
            end
            if (rsp_live_count !== want.live_count) begin
               $display("%0t: live_count expected %0d actual %0d", $time,
                        want.live_count, rsp_live_count);
               error_count++;
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      logic [KEY_BITS-1:0] key_pool [8];
      stim_row_type        row;
      int                  pool_top;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         bucket_key[i]  = '0;
         bucket_data[i] = '0;
         bucket_live[i] = 1'b0;
      end
      recent_index = 0;

      // Lookup of key zero right after reset misses, while a store of it updates slot zero.
      add_row(OP_LOOKUP, '0, '0, 1, ST_MISS, '0, 2'd0);
      add_row(OP_STORE, '0, '1, 1, ST_UPDATE, '0, 2'd1);
      add_row(OP_LOOKUP, '0, '1, 1, ST_HIT, '1, 2'd1);
      add_row(OP_STORE, '1, '0, 1, ST_NEW, '0, 2'd2);
      add_row(OP_STORE, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1, ST_NEW, '0, 2'd3);
      add_row(OP_LOOKUP, '1, 64'h5A5A_5A5A_5A5A_5A5A, 1, ST_HIT, '0, 2'd3);
      add_row(OP_STORE, 64'h0123_4567_89AB_CDEF, 64'd1, 1, ST_COLLIDE, '0, 2'd3);
      add_row(OP_LOOKUP, '0, '0, 0, ST_MISS, '0, '0);
      add_row(OP_STORE, '1, 64'h8000_0000_0000_0001, 0, ST_MISS, '0, '0);
      add_row(OP_STORE, 64'h5555_5555_5555_5555, '0, 0, ST_MISS, '0, '0);
      add_row(OP_LOOKUP, 64'h0123_4567_89AB_CDEF, '1, 0, ST_MISS, '0, '0);
      add_row(OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, '0, 1, ST_MISS, '0, 2'd3);
      add_row(OP_STORE, '0, 64'hFEDC_BA98_7654_3210, 0, ST_MISS, '0, '0);
      add_row(OP_LOOKUP, 64'h5555_5555_5555_5555, '0, 0, ST_MISS, '0, '0);
      add_row(OP_STORE, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 0, ST_MISS, '0, '0);
      add_row(OP_LOOKUP, 64'h8000_0000_0000_0000, '0, 0, ST_MISS, '0, '0);
      add_row(OP_LOOKUP, '0, '0, 0, ST_MISS, '0, '0);
      add_row(OP_STORE, 64'h0123_4567_89AB_CDEF, 64'h0000_0000_FFFF_FFFF, 0, ST_MISS, '0, '0);
      add_row(OP_LOOKUP, 64'h0123_4567_89AB_CDEF, '0, 0, ST_MISS, '0, '0);

      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < 8; i++) begin
         key_pool[i] = {$urandom, $urandom};
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         send_word(directed_rows[i]);
      end
      drain_results();

      row.fixed_answer = 1'b0;
      row.answer       = '0;
      for (int n = 0; n < 1830; n++) begin
         steady_flow = (n >= 800 && n < 1100);
         if (n % 450 == 449) begin
            drain_results();
         end
         if (n % 200 == 199) begin
            key_pool[$urandom_range(7)] = {$urandom, $urandom};
         end
         pool_top = ((n / 300) % 2 == 1) ? 3 : 7;
         row.operation = ($urandom_range(99) < 45) ? OP_LOOKUP : OP_STORE;
         row.key_hash  = ($urandom_range(99) < 85) ? key_pool[$urandom_range(pool_top)]
                                                   : {$urandom, $urandom};
         row.entry_payload = {$urandom, $urandom};
         send_word(row);
      end
      steady_flow = 1'b0;

      drain_results();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
